[sv/linear_probe_hash_table_macros.svh]
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPHT_ASSERT_IMP(label, ante, cons, msg)
`define LPHT_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[sv/lpht_pkg.sv]
// Shared types and constants of the linear-probing hash table.
package lpht_pkg;

    // Table size: a power of two, 4 to 65536.
    localparam int SLOTS      = 64;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int HALF_SLOTS = SLOTS / 2;
    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;

    typedef enum logic [2:0] {
        STATUS_HIT      = 3'd0,
        STATUS_MISS     = 3'd1,
        STATUS_UPDATED  = 3'd2,
        STATUS_INSERTED = 3'd3,
        STATUS_FULL     = 3'd4
    } lpht_status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } lpht_entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } lpht_rd_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        lpht_entry_t      entry;
    } lpht_wr_req_t;

endpackage

[sv/lpht_store.sv]
// Slot store: key/data memory with registered read and per-slot valid flags.
module lpht_store
    import lpht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lpht_rd_req_t rd_req,
    input  lpht_wr_req_t wr_req,
    output logic         rd_valid,
    output lpht_entry_t  rd_entry
);

    lpht_entry_t slot_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic             rd_valid_reg;
    lpht_entry_t      rd_entry_reg;

    // Memory port: write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            slot_mem[wr_req.idx] <= wr_req.entry;
        end
        if (rd_req.en)
        begin
            rd_entry_reg <= slot_mem[rd_req.idx];
        end
    end

    // Valid flags clear at reset; set on every write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_req.en)
            begin
                valid_reg[wr_req.idx] <= 1'b1;
            end
            if (rd_req.en)
            begin
                rd_valid_reg <= valid_reg[rd_req.idx];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_entry = rd_entry_reg;

endmodule

[sv/linear_probe_hash_table.sv]
// Linear-probing hash table: 64 slots of 32-bit key and 32-bit data, one result per item.
// Each item probes from its home slot onward, one slot at a time, until a slot decides; the result is registered.
// Each probe is one read of the slot memory; a new item is not taken until the result reaches the output register.
// The output register frees the input side: a new item is taken while a result waits in it.
// Reset (rst_n, asynchronous) clears all valid flags and the used count at once; no clearing pass.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [KEY_W-1:0]  lookup_key,
    input  logic [DATA_W-1:0] put_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [DATA_W-1:0] read_value
);

`include "linear_probe_hash_table_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_WAIT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_PROBE = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] USED_LIMIT = IDX_W'(HALF_SLOTS);

    state_t            state_reg,     state_next;
    logic              func_reg,      func_next;
    logic [KEY_W-1:0]  key_reg,       key_next;
    logic [DATA_W-1:0] value_reg,     value_next;
    logic [IDX_W-1:0]  idx_reg,       idx_next;
    logic [IDX_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]  used_reg,      used_next;
    lpht_status_t      res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              out_valid_reg, out_valid_next;
    lpht_status_t      out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;

    lpht_rd_req_t rd_req;
    lpht_wr_req_t wr_req;
    logic         rd_valid;
    lpht_entry_t  rd_entry;

    logic         in_accept;
    logic         out_free;
    logic         slot_match;
    logic         slot_empty;
    logic         has_room;
    logic         probe_done;
    lpht_status_t probe_status;
    logic [DATA_W-1:0] probe_value;

    lpht_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_req   (rd_req),
        .wr_req   (wr_req),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry)
    );

    // Take a new item only in idle, not while a result is parked; the output register decouples the output.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Judge the slot just read.
    assign slot_empty = !rd_valid;
    assign slot_match = rd_valid && (rd_entry.key == key_reg);
    assign has_room   = (used_reg < USED_LIMIT);
    assign probe_done = slot_empty || slot_match || (probe_cnt_reg == LAST_PROBE);

    always_comb
    begin
        probe_value = '0;
        if (!func_reg)
        begin
            probe_status = slot_match ? STATUS_HIT : STATUS_MISS;
            if (slot_match)
            begin
                probe_value = rd_entry.data;
            end
        end
        else if (slot_match)
        begin
            probe_status = STATUS_UPDATED;
        end
        else if (slot_empty && has_room)
        begin
            probe_status = STATUS_INSERTED;
        end
        else
        begin
            probe_status = STATUS_FULL;
        end
    end

    // Issue the home slot read on acceptance; advance to the next slot, wrapping, on a probe miss.
    always_comb
    begin
        rd_req.en  = 1'b0;
        rd_req.idx = idx_reg + 1'b1;
        if (in_accept)
        begin
            rd_req.en  = 1'b1;
            rd_req.idx = lookup_key[IDX_W-1:0];
        end
        else if ((state_reg == S_PROBE) && !probe_done)
        begin
            rd_req.en = 1'b1;
        end
    end

    // Write back an update or an insert in the deciding cycle; the next read comes later.
    always_comb
    begin
        wr_req.en         = (state_reg == S_PROBE) && probe_done
                            && ((probe_status == STATUS_UPDATED)
                                || (probe_status == STATUS_INSERTED));
        wr_req.idx        = idx_reg;
        wr_req.entry.key  = key_reg;
        wr_req.entry.data = value_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next      = func;
                    key_next       = lookup_key;
                    value_next     = put_value;
                    idx_next       = lookup_key[IDX_W-1:0];
                    probe_cnt_next = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (probe_done)
                begin
                    if (probe_status == STATUS_INSERTED)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                    // Hand the result straight to the output when it is free, else park it.
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = probe_status;
                        out_value_next  = probe_value;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        res_status_next = probe_status;
                        res_value_next  = probe_value;
                        state_next      = S_WAIT;
                    end
                end
                else
                begin
                    idx_next       = idx_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= 1'b0;
            key_reg        <= '0;
            value_reg      <= '0;
            idx_reg        <= '0;
            probe_cnt_reg  <= '0;
            used_reg       <= '0;
            res_status_reg <= STATUS_MISS;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_MISS;
            out_value_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            key_reg        <= key_next;
            value_reg      <= value_next;
            idx_reg        <= idx_next;
            probe_cnt_reg  <= probe_cnt_next;
            used_reg       <= used_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_value = out_value_reg;

    `LPHT_ASSERT_IMP(a_write_in_probe, wr_req.en, state_reg == S_PROBE, "slot write outside probe")
    `LPHT_ASSERT_IMP(a_used_bound, 1'b1, used_reg <= USED_LIMIT, "used count above half capacity")
    `LPHT_ASSERT_NXT(a_insert_counts, wr_req.en && slot_empty, used_reg == $past(used_reg) + 1'b1, "insert not counted")
    `LPHT_ASSERT_NXT(a_accept_probes, in_accept, state_reg == S_PROBE, "accepted item did not start probing")
    `LPHT_ASSERT_IMP(a_read_not_idle_write, rd_req.en && wr_req.en, 1'b0, "read and write in same cycle")

endmodule
